// ===== rtl/core/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared constants and codes of the first-fit pool allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // default pool geometry
  localparam int POOL_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 24;

  // fixed field widths of the channels
  localparam int REQ_W    = 11;
  localparam int HANDLE_W = 10;
  localparam int PAY_W    = 10;

  // request kind
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_NULL_FREE  = 2'd3
  } status_t;

endpackage

// ===== rtl/core/first_fit_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_top
// first-fit allocator over a byte pool with block headers and coalescing
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel takes one request item: in_tuser selects allocate or free,
//   in_tdata carries the requested payload bytes and the handle to free.
//   out_* channel returns one item per request: status in out_tuser, the
//   payload offset of an allocated block in out_tdata (zero otherwise).
//   Block headers (size and free flag) live in one synchronous RAM indexed
//   by header byte offset. Each allocate, and each free of a handle of at
//   least the header size, walks the chain from offset 0; each visited
//   block is read from the RAM, then evaluated. Allocate then writes the
//   taken header, or on a split the free remainder header and then the
//   shrunk taken header, and posts the result. Free, once it finds the
//   block, reads the block after it for merging when there is one, writes
//   the merged header and posts. A null free or a handle below the header
//   size posts its result without a walk. Throughput is one request at a
//   time, set by the header walk through the single RAM read port; the
//   default pool holds at most 42 blocks. After reset the block writes the
//   header of the single free block at offset 0 and then raises in_tready.
//   A result waits in the output register while out_tready is low; the next
//   request is taken meanwhile and holds its own result until the register
//   is free again.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top #(
  parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // req_bytes[10:0], handle[20:11], zero fill
  input  logic [0:0]  in_tuser,  // func[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // payload_offset[9:0], zero fill
  output logic [1:0]  out_tuser  // status[1:0]
);

  localparam int AW = $clog2(POOL_BYTES);
  localparam int OW = AW + 1;
  localparam int CW = ((OW > ffpa_pkg::REQ_W) ? OW : ffpa_pkg::REQ_W) + 2;
  localparam int DW = AW + 1;
  localparam logic [CW-1:0] H_W    = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] POOL_W = CW'(POOL_BYTES);
  localparam logic [AW-1:0] INIT_SZ = AW'(POOL_BYTES - HEADER_BYTES);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_SPLIT,
    S_NEVAL,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  ffpa_pkg::func_t       func_r, func_nxt;
  logic [ffpa_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [CW-1:0]         tgt_r, tgt_nxt;
  logic [OW-1:0]         o_r, o_nxt;
  logic [OW-1:0]         prv_r, prv_nxt;
  logic [AW-1:0]         prv_sz_r, prv_sz_nxt;
  logic                  prv_free_r, prv_free_nxt;
  logic [AW-1:0]         t_sz_r, t_sz_nxt;
  ffpa_pkg::status_t     res_status_r, res_status_nxt;
  logic [ffpa_pkg::PAY_W-1:0] res_pay_r, res_pay_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ffpa_pkg::status_t     out_status_r, out_status_nxt;
  logic [ffpa_pkg::PAY_W-1:0] out_pay_r, out_pay_nxt;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // decoded header and helper arithmetic
  logic                       rd_free;
  logic [CW-1:0]              sz_w;
  logic [CW-1:0]              o_w;
  logic [CW-1:0]              req_w;
  logic [CW-1:0]              next_w;
  logic [CW-1:0]              hdl_w;
  logic [CW-1:0]              prv_part_w;
  logic [CW-1:0]              merge_w;
  logic [OW-1:0]              start_o;
  logic                       in_fire;
  logic [ffpa_pkg::REQ_W-1:0] in_req;
  logic [ffpa_pkg::HANDLE_W-1:0] in_handle;

  ffpa_hdr_ram #(
    .AW (AW),
    .DW (DW)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_req    = in_tdata[10:0];
  assign in_handle = in_tdata[20:11];

  assign rd_free = ram_rdata[AW];
  assign sz_w    = CW'(ram_rdata[AW-1:0]);
  assign o_w     = CW'(o_r);
  assign req_w   = CW'(req_r);
  assign next_w  = o_w + H_W + sz_w;
  assign hdl_w   = CW'(in_handle);

  // freed block absorbs a free predecessor
  assign prv_part_w = prv_free_r ? (CW'(prv_sz_r) + H_W) : '0;
  assign start_o    = prv_free_r ? prv_r : tgt_r[OW-1:0];

  // read address: walk cursor, or the block after the freed one
  assign ram_raddr = (state_r == S_RD) ? o_r[AW-1:0] : next_w[AW-1:0];

  // control and datapath of the walk
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    req_nxt        = req_r;
    tgt_nxt        = tgt_r;
    o_nxt          = o_r;
    prv_nxt        = prv_r;
    prv_sz_nxt     = prv_sz_r;
    prv_free_nxt   = prv_free_r;
    t_sz_nxt       = t_sz_r;
    res_status_nxt = res_status_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pay_nxt    = out_pay_r;
    ram_we         = 1'b0;
    ram_waddr      = o_r[AW-1:0];
    ram_wdata      = '0;
    merge_w        = '0;

    unique case (state_r)
      S_INIT: begin
        // single free block spanning the pool
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, INIT_SZ};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_fire) begin
          func_nxt     = ffpa_pkg::func_t'(in_tuser[0]);
          req_nxt      = in_req;
          tgt_nxt      = hdl_w - H_W;
          o_nxt        = '0;
          prv_free_nxt = 1'b0;
          res_pay_nxt  = '0;
          if (in_tuser[0] == ffpa_pkg::FUNC_ALLOC) begin
            res_status_nxt = ffpa_pkg::ST_NO_SPACE;
            state_nxt      = S_RD;
          end else if (in_handle == '0) begin
            res_status_nxt = ffpa_pkg::ST_NULL_FREE;
            state_nxt      = S_RESP;
          end else if (hdl_w < H_W) begin
            res_status_nxt = ffpa_pkg::ST_BAD_HANDLE;
            state_nxt      = S_RESP;
          end else begin
            res_status_nxt = ffpa_pkg::ST_BAD_HANDLE;
            state_nxt      = S_RD;
          end
        end
      end

      S_RD: begin
        // end of chain, or walked past the handle
        if (o_w >= POOL_W ||
            (func_r == ffpa_pkg::FUNC_FREE && o_w > tgt_r)) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (func_r == ffpa_pkg::FUNC_ALLOC) begin
          if (rd_free && sz_w >= req_w) begin
            res_status_nxt = ffpa_pkg::ST_OK;
            res_pay_nxt    = ffpa_pkg::PAY_W'(o_w + H_W);
            ram_we         = 1'b1;
            if (sz_w > req_w + H_W) begin
              // free remainder after the taken payload
              ram_waddr = AW'(o_w + H_W + req_w);
              ram_wdata = {1'b1, AW'(sz_w - req_w - H_W)};
              state_nxt = S_SPLIT;
            end else begin
              ram_waddr = o_r[AW-1:0];
              ram_wdata = {1'b0, ram_rdata[AW-1:0]};
              state_nxt = S_RESP;
            end
          end else begin
            o_nxt     = (next_w >= POOL_W) ? OW'(POOL_BYTES) : next_w[OW-1:0];
            state_nxt = S_RD;
          end
        end else if (o_w == tgt_r) begin
          // found the block to free
          t_sz_nxt       = ram_rdata[AW-1:0];
          res_status_nxt = ffpa_pkg::ST_OK;
          if (next_w < POOL_W) begin
            state_nxt = S_NEVAL;
          end else begin
            merge_w   = prv_part_w + sz_w;
            ram_we    = 1'b1;
            ram_waddr = start_o[AW-1:0];
            ram_wdata = {1'b1, merge_w[AW-1:0]};
            state_nxt = S_RESP;
          end
        end else begin
          prv_nxt      = o_r;
          prv_sz_nxt   = ram_rdata[AW-1:0];
          prv_free_nxt = rd_free;
          o_nxt        = (next_w >= POOL_W) ? OW'(POOL_BYTES) : next_w[OW-1:0];
          state_nxt    = S_RD;
        end
      end

      S_SPLIT: begin
        // shrink the taken block to the request
        ram_we    = 1'b1;
        ram_waddr = o_r[AW-1:0];
        ram_wdata = {1'b0, req_w[AW-1:0]};
        state_nxt = S_RESP;
      end

      S_NEVAL: begin
        // merge with the following block when it is free
        merge_w   = prv_part_w + CW'(t_sz_r) + (rd_free ? (H_W + sz_w) : '0);
        ram_we    = 1'b1;
        ram_waddr = start_o[AW-1:0];
        ram_wdata = {1'b1, merge_w[AW-1:0]};
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pay_nxt    = res_pay_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    req_r        <= req_nxt;
    tgt_r        <= tgt_nxt;
    o_r          <= o_nxt;
    prv_r        <= prv_nxt;
    prv_sz_r     <= prv_sz_nxt;
    prv_free_r   <= prv_free_nxt;
    t_sz_r       <= t_sz_nxt;
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(16 - ffpa_pkg::PAY_W){1'b0}}, out_pay_r};

`ifndef NO_ASSERTIONS
  // header store is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != S_IDLE)
    else $error("header write while idle");

  // a result is loaded only from the posting state
  a_post_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result posted outside posting state");

  // a pending result holds the posting state while the output is stalled
  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_tready) |=> state_r == S_RESP)
    else $error("pending result lost under stall");

  // only a successful result carries a payload offset
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ffpa_pkg::ST_OK) |-> out_pay_r == '0)
    else $error("payload offset on failed request");
`endif

endmodule

// ===== rtl/core/ffpa_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_hdr_ram
// block header store: one write port, one registered read port
// ----------------------------------------------------------------------------
module ffpa_hdr_ram #(
  parameter int AW = 10,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== verif/first_fit_pool_allocator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_top_test
// self-checking bench for the first-fit pool allocator: a shadow copy of the
// block headers predicts status and payload offset of every accepted request,
// results are matched in order; directed corner items first, then random
// allocate / free traffic with occasional drains, random gaps and stalls
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top_test;

  localparam int POOL     = ffpa_pkg::POOL_BYTES_DEF;
  localparam int HDR      = ffpa_pkg::HEADER_BYTES_DEF;
  localparam int N_ITEMS  = 1400;
  localparam int IDLE_MAX = 5000;

  typedef struct packed {
    ffpa_pkg::status_t               status;
    logic [ffpa_pkg::PAY_W-1:0]      offset;
  } alloc_result_t;

  // shadow header store, expected result queue and result checking
  class heap_checker;
    int unsigned     blk_size [POOL];
    bit              blk_free [POOL];
    alloc_result_t   pending_results [$];
    int unsigned     mismatches;

    function new();
      foreach (blk_size[k]) begin
        blk_size[k] = 0;
        blk_free[k] = 1'b0;
      end
      blk_size[0] = POOL - HDR;
      blk_free[0] = 1'b1;
      mismatches  = 0;
    endfunction

    // fold every run of adjacent free blocks into its first block
    function void coalesce();
      int unsigned o;
      int unsigned n;
      o = 0;
      while (o < POOL) begin
        n = o + HDR + blk_size[o];
        if (blk_free[o] && n < POOL && blk_free[n])
          blk_size[o] = blk_size[o] + HDR + blk_size[n];
        else
          o = n;
      end
    endfunction

    // apply one request to the shadow headers and return its result
    function alloc_result_t walk_pool(ffpa_pkg::func_t f, int unsigned req,
                                      int unsigned hnd);
      alloc_result_t r;
      int unsigned   o;
      int unsigned   sz;
      int unsigned   nb;
      int unsigned   target;
      r.status = ffpa_pkg::ST_NO_SPACE;
      r.offset = '0;
      o = 0;
      if (f == ffpa_pkg::FUNC_ALLOC) begin
        while (o < POOL) begin
          sz = blk_size[o];
          if (blk_free[o] && sz >= req) begin
            // split off the tail only if it can hold a header and more
            if (sz > req + HDR) begin
              nb = o + HDR + req;
              blk_size[nb] = sz - req - HDR;
              blk_free[nb] = 1'b1;
              blk_size[o]  = req;
            end
            blk_free[o] = 1'b0;
            r.status = ffpa_pkg::ST_OK;
            r.offset = ffpa_pkg::PAY_W'(o + HDR);
            break;
          end
          o = o + HDR + blk_size[o];
        end
      end else if (hnd == 0) begin
        r.status = ffpa_pkg::ST_NULL_FREE;
      end else begin
        r.status = ffpa_pkg::ST_BAD_HANDLE;
        if (hnd >= HDR) begin
          target = hnd - HDR;
          while (o < POOL && o < target)
            o = o + HDR + blk_size[o];
          if (o == target && o < POOL) begin
            blk_free[o] = 1'b1;
            coalesce();
            r.status = ffpa_pkg::ST_OK;
          end
        end
      end
      return r;
    endfunction

    function alloc_result_t note_request(ffpa_pkg::func_t f, int unsigned req,
                                         int unsigned hnd);
      alloc_result_t r;
      r = walk_pool(f, req, hnd);
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(ffpa_pkg::status_t st,
                               logic [ffpa_pkg::PAY_W-1:0] offset);
      alloc_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d, payload_offset %0d",
               st, offset);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (st !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, st);
        mismatches++;
      end
      if (offset !== exp.offset) begin
        $error("payload_offset: expected %0d, actual %0d", exp.offset, offset);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // req_bytes[10:0], handle[20:11], zero fill
  logic [0:0]  in_tuser = '0;   // func[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // payload_offset[9:0], zero fill
  logic [1:0]  out_tuser;       // status[1:0]

  heap_checker  sb;
  int unsigned  live_handles [$];
  int unsigned  freed_handles [$];
  int unsigned  items_sent;
  int unsigned  idle_cycles = 0;
  bit           burst;

  first_fit_pool_allocator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_req_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 64);
    if (roll < 90) return $urandom_range(65, 300);
    if (roll < 98) return $urandom_range(301, 1000);
    return $urandom_range(1001, 1024);
  endfunction

  // drive one request item, wait for its handshake, update the handle lists
  task automatic send_req(input ffpa_pkg::func_t f, input int unsigned req,
                          input int unsigned hnd);
    int unsigned   gap;
    int unsigned   k;
    alloc_result_t r;
    bit            found;
    logic [ffpa_pkg::REQ_W-1:0]    req_f;
    logic [ffpa_pkg::HANDLE_W-1:0] hnd_f;
    gap   = pick_gap();
    req_f = ffpa_pkg::REQ_W'(req);
    hnd_f = ffpa_pkg::HANDLE_W'(hnd);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {3'b000, hnd_f, req_f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = sb.note_request(f, req_f, hnd_f);
    items_sent++;
    if (r.status == ffpa_pkg::ST_OK) begin
      if (f == ffpa_pkg::FUNC_ALLOC) begin
        live_handles.push_back(r.offset);
      end else begin
        found = 1'b0;
        for (k = 0; k < live_handles.size() && !found; k++) begin
          if (live_handles[k] == hnd_f) begin
            live_handles.delete(k);
            found = 1'b1;
          end
        end
        freed_handles.push_back(hnd_f);
        if (freed_handles.size() > 32) void'(freed_handles.pop_front());
      end
    end
  endtask

  // free every live block in random order, leaving the pool fully merged
  task automatic drain_live();
    int unsigned idx;
    while (live_handles.size() != 0) begin
      idx = $urandom_range(0, live_handles.size() - 1);
      send_req(ffpa_pkg::FUNC_FREE, $urandom_range(0, 1024), live_handles[idx]);
    end
  endtask

  // one random item: allocations biased by fill level, frees mostly legal
  task automatic random_item();
    int unsigned roll;
    int unsigned p_alloc;
    p_alloc = (live_handles.size() > 20) ? 35 : 55;
    roll = $urandom_range(0, 99);
    if (live_handles.size() == 0 || roll < p_alloc) begin
      send_req(ffpa_pkg::FUNC_ALLOC, pick_req_size(), $urandom_range(0, 1023));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 75)
        send_req(ffpa_pkg::FUNC_FREE, $urandom_range(0, 1024),
                 live_handles[$urandom_range(0, live_handles.size() - 1)]);
      else if (roll < 83 && freed_handles.size() != 0)
        send_req(ffpa_pkg::FUNC_FREE, $urandom_range(0, 1024),
                 freed_handles[$urandom_range(0, freed_handles.size() - 1)]);
      else if (roll < 90)
        send_req(ffpa_pkg::FUNC_FREE, $urandom_range(0, 1024),
                 $urandom_range(1, 1023));
      else if (roll < 95)
        send_req(ffpa_pkg::FUNC_FREE, $urandom_range(0, 1024), 0);
      else
        send_req(ffpa_pkg::FUNC_FREE, $urandom_range(0, 1024),
                 $urandom_range(1, HDR - 1));
    end
  endtask

  // result side: random back-pressure with stall-free stretches
  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(ffpa_pkg::status_t'(out_tuser),
                      out_tdata[ffpa_pkg::PAY_W-1:0]);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    sb          = new();
    items_sent  = 0;
    burst       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // null, double free of the reset block, handle inside the first header
    send_req(ffpa_pkg::FUNC_FREE, 0, 0);
    send_req(ffpa_pkg::FUNC_FREE, 1024, HDR);
    send_req(ffpa_pkg::FUNC_FREE, 0, 5);
    // requests larger than the free payload of the pool
    send_req(ffpa_pkg::FUNC_ALLOC, 1024, 1023);
    send_req(ffpa_pkg::FUNC_ALLOC, POOL - HDR + 1, 0);
    // exact fit, then a zero request with nothing free
    send_req(ffpa_pkg::FUNC_ALLOC, POOL - HDR, 0);
    send_req(ffpa_pkg::FUNC_ALLOC, 0, 0);
    send_req(ffpa_pkg::FUNC_FREE, 0, HDR);
    // near fit: remainder equals one header, no split
    send_req(ffpa_pkg::FUNC_ALLOC, POOL - 2 * HDR, 0);
    send_req(ffpa_pkg::FUNC_FREE, 0, HDR);
    // split leaving a one byte tail, zero request lands at the last offset
    send_req(ffpa_pkg::FUNC_ALLOC, POOL - 2 * HDR - 1, 0);
    send_req(ffpa_pkg::FUNC_ALLOC, 0, 0);
    send_req(ffpa_pkg::FUNC_FREE, 0, 1023);
    send_req(ffpa_pkg::FUNC_FREE, 0, HDR);
    // several blocks, a hole, a bad handle inside a payload, first-fit reuse
    send_req(ffpa_pkg::FUNC_ALLOC, 0, 0);
    send_req(ffpa_pkg::FUNC_ALLOC, 100, 0);
    send_req(ffpa_pkg::FUNC_ALLOC, 200, 0);
    send_req(ffpa_pkg::FUNC_FREE, 0, 2 * HDR);
    send_req(ffpa_pkg::FUNC_FREE, 0, 100);
    send_req(ffpa_pkg::FUNC_ALLOC, 50, 0);
    send_req(ffpa_pkg::FUNC_FREE, 0, 1023);
    send_req(ffpa_pkg::FUNC_FREE, 0, 2 * HDR);
    drain_live();

    // random traffic with an occasional full drain
    while (items_sent < N_ITEMS) begin
      if (items_sent % 100 < 4) burst = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 249) == 0) drain_live();
      else random_item();
    end
    drain_live();
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_hdr_ram.sv
rtl/core/first_fit_pool_allocator_top.sv
verif/first_fit_pool_allocator_top_test.sv
